### rtl/hec_pkg.sv
package hec_pkg;

    localparam int LEN_BITS   = 6;
    localparam int MSG_BITS   = 57;
    localparam int CODE_BITS  = 63;
    localparam int SYN_BITS   = 6;
    localparam int STAT_BITS  = 2;
    localparam int S_TDATA_W  = 120;
    localparam int M_TDATA_W  = 128;

    typedef logic [LEN_BITS-1:0]  len_t;
    typedef logic [MSG_BITS-1:0]  data_t;
    typedef logic [CODE_BITS-1:0] code_t;
    typedef logic [SYN_BITS-1:0]  syn_t;
    typedef logic [STAT_BITS-1:0] status_t;

    localparam status_t ST_OK            = 2'd0;
    localparam status_t ST_CORRECTED     = 2'd1;
    localparam status_t ST_UNCORRECTABLE = 2'd2;

    // 0 acts as 1, anything above the build limit acts as the limit
    function automatic len_t eff_len(input len_t value, input int max_len);
        len_t m;
        m = value;
        if (m == '0)
            m = len_t'(1);
        if (int'(m) > max_len)
            m = len_t'(max_len);
        return m;
    endfunction

    // codeword length n = m + r, r the smallest with 2^r >= m + r + 1
    function automatic len_t code_len(input len_t m);
        int r;
        r = 0;
        for (int i = 0; i < 7; i++)
        begin
            if ((1 << r) < int'(m) + r + 1)
                r = r + 1;
        end
        return len_t'(int'(m) + r);
    endfunction

    // data bit held at code bit j: j less the parity slots at or below position j + 1
    function automatic int data_index(input int j);
        int idx;
        idx = j;
        for (int i = 0; i < SYN_BITS; i++)
        begin
            if ((1 << i) <= j + 1)
                idx = idx - 1;
        end
        return idx;
    endfunction

endpackage

### rtl/hec_core.sv
module hec_core (
    input  logic             func,
    input  hec_pkg::data_t   msg,
    input  hec_pkg::code_t   rx,
    input  hec_pkg::len_t    len,
    input  hec_pkg::len_t    n,
    output hec_pkg::code_t   code,
    output hec_pkg::data_t   data,
    output hec_pkg::syn_t    syn,
    output hec_pkg::status_t status
);
    import hec_pkg::*;

    data_t   msg_m;
    code_t   base;
    syn_t    par;
    code_t   fixed;
    status_t st;

    always_comb
    begin
        for (int k = 0; k < MSG_BITS; k++)
            msg_m[k] = msg[k] & (LEN_BITS'(k) < len);

        // encode: scatter data over the non power of two positions
        // check: received code limited to n positions
        for (int j = 0; j < CODE_BITS; j++)
        begin
            if (func)
                base[j] = rx[j] & (LEN_BITS'(j) < n);
            else if (((j + 1) & j) == 0)
                base[j] = 1'b0;
            else
                base[j] = msg_m[data_index(j)];
        end

        // groups above n see only zeros, so their parity is 0
        par = '0;
        for (int j = 0; j < CODE_BITS; j++)
        begin
            for (int i = 0; i < SYN_BITS; i++)
            begin
                if (((j + 1) & (1 << i)) != 0)
                    par[i] = par[i] ^ base[j];
            end
        end

        if (!func)
            st = ST_OK;
        else if (par == '0)
            st = ST_OK;
        else if (par <= n)
            st = ST_CORRECTED;
        else
            st = ST_UNCORRECTABLE;

        fixed = base;
        if (!func)
        begin
            for (int i = 0; i < SYN_BITS; i++)
                fixed[(1 << i) - 1] = par[i];
        end
        else
        begin
            for (int j = 0; j < CODE_BITS; j++)
                fixed[j] = base[j] ^ ((par == SYN_BITS'(j + 1)) && (st == ST_CORRECTED));
        end

        for (int j = 0; j < CODE_BITS; j++)
        begin
            if (((j + 1) & j) != 0)
                data[data_index(j)] = fixed[j];
        end
    end

    assign code   = fixed;
    assign syn    = func ? par : '0;
    assign status = st;

endmodule

### rtl/hamming_encode_correct.sv
// Hamming single-error-correcting encoder and checker. Takes one item per clock
// while the output is not stalled: the item is registered on entry, the
// scatter, parity and correction logic is combinational, and the result sits in
// the output register until taken. s_tready follows m_tready through the two
// stages, so both stay full under back-pressure. s_tuser[0] selects encode (0)
// or check and correct (1). cfg_wdata sets the message length m (0 acts as 1,
// values above MAX_DATA_BITS act as MAX_DATA_BITS) and is used by items accepted
// after the write; write it only while no item is in flight.
module hamming_encode_correct #(
    parameter int MAX_DATA_BITS = 57
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hec_pkg::LEN_BITS-1:0]  cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // message_bits [56:0], received_code [119:57]
    input  logic [hec_pkg::S_TDATA_W-1:0] s_tdata,
    // func [0]
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // code_out [62:0], data_out [119:63], syndrome [125:120], status [127:126]
    output logic [hec_pkg::M_TDATA_W-1:0] m_tdata
);
    import hec_pkg::*;

    localparam len_t RESET_LEN = eff_len(len_t'(MAX_DATA_BITS), MAX_DATA_BITS);
    localparam len_t RESET_N   = code_len(RESET_LEN);

    len_t  len_reg;
    len_t  n_reg;
    len_t  len_next;

    logic  in_valid_reg;
    logic  in_valid_next;
    logic  in_func_reg;
    data_t in_msg_reg;
    code_t in_rx_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [M_TDATA_W-1:0] out_tdata_reg;

    logic    out_ready;
    logic    in_ready;
    code_t   core_code;
    data_t   core_data;
    syn_t    core_syn;
    status_t core_status;

    assign out_ready = !out_valid_reg || m_tready;
    assign in_ready  = !in_valid_reg || out_ready;

    assign len_next       = eff_len(cfg_wdata, MAX_DATA_BITS);
    assign in_valid_next  = in_ready ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_ready ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= RESET_LEN;
            n_reg         <= RESET_N;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= len_next;
                n_reg   <= code_len(len_next);
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_tvalid)
        begin
            in_func_reg <= s_tuser[0];
            in_msg_reg  <= s_tdata[MSG_BITS-1:0];
            in_rx_reg   <= s_tdata[MSG_BITS+CODE_BITS-1:MSG_BITS];
        end
        if (out_ready && in_valid_reg)
            out_tdata_reg <= {core_status, core_syn, core_data, core_code};
    end

    hec_core u_core (
        .func   (in_func_reg),
        .msg    (in_msg_reg),
        .rx     (in_rx_reg),
        .len    (len_reg),
        .n      (n_reg),
        .code   (core_code),
        .data   (core_data),
        .syn    (core_syn),
        .status (core_status)
    );

    assign s_tready = in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;

endmodule

### rtl/hec_checker.sv
module hec_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hec_pkg::M_TDATA_W-1:0] m_tdata
);
    import hec_pkg::*;

    syn_t    syn;
    status_t st;

    assign syn = m_tdata[125:120];
    assign st  = m_tdata[127:126];

    // a held result stays put until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (st == ST_OK || st == ST_CORRECTED || st == ST_UNCORRECTABLE))
        else $error("unused status code");

    // clean status exactly when the syndrome is zero
    a_syn_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((syn == '0) == (st == ST_OK)))
        else $error("syndrome and status disagree");

    // an accepted item with a free output stage reaches m_tvalid
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (!m_tvalid || m_tready) |=> ##1 m_tvalid)
        else $error("item lost in the pipeline");

endmodule

bind hamming_encode_correct hec_checker u_hec_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
